// ----- hdl/nsc_pkg.sv -----
package nsc_pkg;

	// Verdict codes carried on the result channel
	typedef enum logic [1:0] {
		VERDICT_INVALID = 2'd0,
		VERDICT_INTEGER = 2'd1,
		VERDICT_DECIMAL = 2'd2
	} verdict_t;

	// Character classes seen by the flag tracker
	typedef enum logic [2:0] {
		CLS_END,
		CLS_SPACE,
		CLS_SIGN,
		CLS_DOT,
		CLS_ZERO,
		CLS_NONZERO,
		CLS_OTHER
	} char_class_t;

	// Per-string parsing flags
	typedef struct packed {
		logic at_first;
		logic leading_zone;
		logic trailing_space;
		logic sign_pending;
		logic dot_seen;
		logic nonzero_fraction;
		logic rejected;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{
		at_first:         1'b1,
		leading_zone:     1'b0,
		trailing_space:   1'b0,
		sign_pending:     1'b0,
		dot_seen:         1'b0,
		nonzero_fraction: 1'b0,
		rejected:         1'b0
	};

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Map one byte onto its character class
	function automatic char_class_t classify(input logic [7:0] ch);
		char_class_t cls;
		cls = CLS_OTHER;
		case (ch) inside
			CH_NUL:                         cls = CLS_END;
			CH_SPACE, CH_TAB, CH_LF, CH_CR: cls = CLS_SPACE;
			CH_PLUS, CH_MINUS:              cls = CLS_SIGN;
			CH_DOT:                         cls = CLS_DOT;
			CH_ZERO:                        cls = CLS_ZERO;
			[CH_ONE:CH_NINE]:               cls = CLS_NONZERO;
			default:                        cls = CLS_OTHER;
		endcase
		return cls;
	endfunction

endpackage

// ----- hdl/nsc_track.sv -----
module nsc_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        symbol,
	output logic              is_end,
	output nsc_pkg::verdict_t verdict
);

	nsc_pkg::flags_t      flags_q;
	nsc_pkg::flags_t      flags_next;
	nsc_pkg::char_class_t cls;
	logic                 open_zone;

	assign cls    = nsc_pkg::classify(symbol);
	assign is_end = (cls == nsc_pkg::CLS_END);

	// Form the verdict from the flags in force when the terminator arrives
	always_comb begin
		if (flags_q.rejected || flags_q.at_first || flags_q.sign_pending) begin
			verdict = nsc_pkg::VERDICT_INVALID;
		end else if (flags_q.dot_seen && flags_q.nonzero_fraction) begin
			verdict = nsc_pkg::VERDICT_DECIMAL;
		end else begin
			verdict = nsc_pkg::VERDICT_INTEGER;
		end
	end

	// Advance the flags by one character
	always_comb begin
		open_zone  = flags_q.at_first || flags_q.leading_zone;
		flags_next = flags_q;
		if (is_end) begin
			flags_next = nsc_pkg::FLAGS_RESET;
		end else if (!flags_q.rejected) begin
			flags_next.at_first     = 1'b0;
			flags_next.leading_zone = open_zone;
			case (cls)
				nsc_pkg::CLS_SPACE: begin
					if (!open_zone) flags_next.trailing_space = 1'b1;
				end
				nsc_pkg::CLS_SIGN: begin
					if (!open_zone) begin
						flags_next.rejected = 1'b1;
					end else begin
						flags_next.leading_zone   = 1'b0;
						flags_next.trailing_space = 1'b0;
						flags_next.sign_pending   = 1'b1;
					end
				end
				nsc_pkg::CLS_DOT: begin
					if (flags_q.dot_seen) flags_next.rejected = 1'b1;
					else flags_next.dot_seen = 1'b1;
				end
				nsc_pkg::CLS_ZERO, nsc_pkg::CLS_NONZERO: begin
					if (cls == nsc_pkg::CLS_NONZERO && flags_q.dot_seen) begin
						flags_next.nonzero_fraction = 1'b1;
					end
					flags_next.sign_pending = 1'b0;
					flags_next.leading_zone = 1'b0;
					if (flags_q.trailing_space) flags_next.rejected = 1'b1;
				end
				default: begin
					flags_next.rejected = 1'b1;
				end
			endcase
		end
	end

	// Hold the flags until a character is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= nsc_pkg::FLAGS_RESET;
		end else if (take) begin
			flags_q <= flags_next;
		end
	end

endmodule

// ----- hdl/numeric_string_classifier_top.sv -----
// Channel  | Direction | Handshake           | Payload
// input    | in        | in_valid, in_stall  | symbol[7:0]
// result   | out       | out_valid, out_stall| verdict[1:0]
//
// One character is taken per cycle while in_stall is low; a verdict becomes
// valid once its terminator has passed the input register, then the result register.
// Only a terminator produces a result transaction; other characters only
// update the flags as they leave the input register.
// Reset clears the flags to the start-of-string state and empties both registers.
// in_stall rises only when a terminator waits in the input register while an
// unaccepted verdict is stalled in the result register.
module numeric_string_classifier_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] verdict
);

	logic              valid_s1;
	logic [7:0]        symbol_s1;
	logic              is_end;
	logic              out_free;
	logic              advance;
	nsc_pkg::verdict_t verdict_comb;
	nsc_pkg::verdict_t verdict_q;

	nsc_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (advance),
		.symbol  (symbol_s1),
		.is_end  (is_end),
		.verdict (verdict_comb)
	);

	// Drain the input register unless a terminator meets a full, stalled output
	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && (!is_end || out_free);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			symbol_s1 <= symbol;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= advance && is_end;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && is_end) begin
			verdict_q <= verdict_comb;
		end
	end

	assign verdict = verdict_q;

endmodule

// ----- hdl/nsc_checker.sv -----
module nsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] symbol,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] verdict
);

	// Hold a stalled result transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict))
	else $error("stalled verdict changed or dropped");

	// Verdict stays within its defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == nsc_pkg::VERDICT_INVALID ||
			verdict == nsc_pkg::VERDICT_INTEGER ||
			verdict == nsc_pkg::VERDICT_DECIMAL))
	else $error("verdict code out of range");

	// Back-pressure on the input only comes from a blocked result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
	else $error("input stalled without a blocked result");

	// A verdict rising from idle follows a terminator accepted through the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past(in_valid && !in_stall && symbol == nsc_pkg::CH_NUL, 2))
	else $error("verdict without a terminator");

endmodule

bind numeric_string_classifier_top nsc_checker u_nsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.symbol    (symbol),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.verdict   (verdict)
);

// ----- test/tb_numeric_string_classifier_top.sv -----
`timescale 1ns / 1ps

module tb_numeric_string_classifier_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIRECTED_ROWS = 26;

	// One directed row: a character, plus a verdict typed in where it is obvious
	typedef struct packed {
		logic [7:0]        ch;
		logic              typed;
		nsc_pkg::verdict_t want;
	} directed_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] symbol = nsc_pkg::CH_NUL;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] verdict;

	nsc_pkg::flags_t   string_flags = nsc_pkg::FLAGS_RESET;
	nsc_pkg::verdict_t expected_verdicts [$];
	int         symbols_sent = 0;
	int         sender_idle_pct = 0;
	int         receiver_stall_pct = 0;
	logic       hold_request = 1'b0;
	int         hold_left = 0;
	int         mismatch_count = 0;
	int         cycle_count = 0;

	directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{nsc_pkg::CH_NUL,   1'b1, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_SPACE, 1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_TAB,   1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_NUL,   1'b1, nsc_pkg::VERDICT_INTEGER},
		'{nsc_pkg::CH_DOT,   1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_NUL,   1'b1, nsc_pkg::VERDICT_INTEGER},
		'{nsc_pkg::CH_MINUS, 1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_NUL,   1'b1, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_LF,    1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_PLUS,  1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_ONE,   1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_DOT,   1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_NINE,  1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_CR,    1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_NUL,   1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_ZERO,  1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_DOT,   1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_ZERO,  1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_NUL,   1'b1, nsc_pkg::VERDICT_INTEGER},
		'{8'hFF,             1'b0, nsc_pkg::VERDICT_INVALID},
		'{8'h35,             1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_NUL,   1'b1, nsc_pkg::VERDICT_INVALID},
		'{8'h37,             1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_SPACE, 1'b0, nsc_pkg::VERDICT_INVALID},
		'{8'h33,             1'b0, nsc_pkg::VERDICT_INVALID},
		'{nsc_pkg::CH_NUL,   1'b0, nsc_pkg::VERDICT_INVALID}
	};

	numeric_string_classifier_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the string flags by one character; return 1 when a verdict is due
	function automatic logic track_symbol(input logic [7:0] ch,
		output nsc_pkg::verdict_t v);
		logic open;
		v = nsc_pkg::VERDICT_INVALID;
		if (ch == nsc_pkg::CH_NUL) begin
			if (string_flags.rejected || string_flags.at_first ||
				string_flags.sign_pending)
				v = nsc_pkg::VERDICT_INVALID;
			else if (string_flags.dot_seen && string_flags.nonzero_fraction)
				v = nsc_pkg::VERDICT_DECIMAL;
			else
				v = nsc_pkg::VERDICT_INTEGER;
			string_flags = nsc_pkg::FLAGS_RESET;
			return 1'b1;
		end
		// a rejected string ignores everything up to its terminator
		if (!string_flags.rejected) begin
			open = string_flags.at_first | string_flags.leading_zone;
			string_flags.at_first = 1'b0;
			string_flags.leading_zone = open;
			if (ch == nsc_pkg::CH_SPACE || ch == nsc_pkg::CH_TAB ||
				ch == nsc_pkg::CH_LF || ch == nsc_pkg::CH_CR) begin
				if (!open)
					string_flags.trailing_space = 1'b1;
			end else if (ch == nsc_pkg::CH_PLUS || ch == nsc_pkg::CH_MINUS) begin
				if (!open) begin
					string_flags.rejected = 1'b1;
				end else begin
					string_flags.leading_zone = 1'b0;
					string_flags.trailing_space = 1'b0;
					string_flags.sign_pending = 1'b1;
				end
			end else if (ch == nsc_pkg::CH_DOT) begin
				if (string_flags.dot_seen)
					string_flags.rejected = 1'b1;
				else
					string_flags.dot_seen = 1'b1;
			end else if (ch >= nsc_pkg::CH_ZERO && ch <= nsc_pkg::CH_NINE) begin
				if (ch >= nsc_pkg::CH_ONE && string_flags.dot_seen)
					string_flags.nonzero_fraction = 1'b1;
				string_flags.sign_pending = 1'b0;
				string_flags.leading_zone = 1'b0;
				if (string_flags.trailing_space)
					string_flags.rejected = 1'b1;
			end else begin
				string_flags.rejected = 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] random_space();
		case ($urandom_range(0, 3))
			0:       return nsc_pkg::CH_SPACE;
			1:       return nsc_pkg::CH_TAB;
			2:       return nsc_pkg::CH_LF;
			default: return nsc_pkg::CH_CR;
		endcase
	endfunction

	// Lean toward zero so that fractions of all zeros show up often
	function automatic logic [7:0] random_digit();
		if ($urandom_range(0, 9) < 3)
			return nsc_pkg::CH_ZERO;
		return nsc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_sign();
		return $urandom_range(0, 1) ? nsc_pkg::CH_PLUS : nsc_pkg::CH_MINUS;
	endfunction

	// Offer one character, hold it until taken, then record its expected verdict
	task automatic send_symbol(input logic [7:0] ch, input logic typed,
		input nsc_pkg::verdict_t want);
		nsc_pkg::verdict_t predicted;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		symbol <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		symbols_sent++;
		if (track_symbol(ch, predicted))
			expected_verdicts.insert(expected_verdicts.size(), typed ? want : predicted);
	endtask

	// Build one string, mostly well formed, and send it with its terminator
	task automatic send_random_string();
		logic [7:0] text [$];
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// raw noise, any byte at all
			repeat ($urandom_range(0, 6))
				text.insert(text.size(), 8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) text.insert(text.size(), random_space());
			if ($urandom_range(0, 5) == 0)
				text.insert(text.size(), nsc_pkg::CH_DOT);
			if ($urandom_range(0, 2) == 0)
				text.insert(text.size(), random_sign());
			repeat ($urandom_range(0, 3)) text.insert(text.size(), random_digit());
			if ($urandom_range(0, 1)) begin
				text.insert(text.size(), nsc_pkg::CH_DOT);
				repeat ($urandom_range(0, 3)) text.insert(text.size(), random_digit());
			end
			repeat ($urandom_range(0, 2)) text.insert(text.size(), random_space());
			// break a fifth of the well-formed strings
			if (pick >= 80) begin
				case ($urandom_range(0, 3))
					0: text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));
					1: text.insert($urandom_range(0, text.size()), nsc_pkg::CH_DOT);
					2: text.insert($urandom_range(0, text.size()), random_sign());
					default: begin
						text.insert(text.size(), random_space());
						text.insert(text.size(), random_digit());
					end
				endcase
			end
		end
		text.insert(text.size(), nsc_pkg::CH_NUL);
		foreach (text[i])
			send_symbol(text[i], 1'b0, nsc_pkg::VERDICT_INVALID);
	endtask

	task automatic run_strings(input int budget);
		int target;
		target = symbols_sent + budget;
		while (symbols_sent < target)
			send_random_string();
	endtask

	// Check each verdict transaction, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				if (mismatch_count < 10)
					$display("verdict %0d with none expected", verdict);
				mismatch_count++;
			end else begin
				if (verdict !== expected_verdicts[0]) begin
					if (mismatch_count < 10)
						$display("verdict mismatch: expected %0d, got %0d",
							expected_verdicts[0], verdict);
					mismatch_count++;
				end
				void'(expected_verdicts.pop_front());
			end
		end
		if (hold_request)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		out_stall <= hold_request || (hold_left > 1) ||
			($urandom_range(0, 99) < receiver_stall_pct);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("numeric_string_classifier_top regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_symbol(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);

		run_strings(250);
		sender_idle_pct = 85;
		run_strings(200);
		sender_idle_pct = 0;
		receiver_stall_pct = 85;
		run_strings(250);
		sender_idle_pct = 34;
		receiver_stall_pct = 34;
		run_strings(250);

		// hold off the receiver while the sender keeps the input full
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		in_valid <= 1'b0;
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		run_strings(100);

		// drain
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
			$display("numeric_string_classifier_top regression: pass");
		end else begin
			$display("numeric_string_classifier_top regression: fail");
		end
		$finish;
	end

endmodule
